@@ design/abkf_pkg.sv @@
// Package for the angle/bias Kalman filter: formats, operation codes, controller states,
// the command type between controller and datapath, and the saturation helper.
// Used by every module of the block; depends on nothing.
`default_nettype none

package abkf_pkg;

	localparam int FRAC_BITS   = 24;
	localparam int DIV_STEPS   = 56;
	localparam int DIV_CNT_W   = 6;
	localparam int REG_INDEX_W = 2;
	localparam int NOISE_W     = 31;

	localparam logic [REG_INDEX_W-1:0] REG_ANGLE_NOISE = 2'd0;
	localparam logic [REG_INDEX_W-1:0] REG_BIAS_NOISE  = 2'd1;
	localparam logic [REG_INDEX_W-1:0] REG_MEAS_NOISE  = 2'd2;

	localparam logic [NOISE_W-1:0] ANGLE_NOISE_RESET = 31'd16777;
	localparam logic [NOISE_W-1:0] BIAS_NOISE_RESET  = 31'd50332;
	localparam logic [NOISE_W-1:0] MEAS_NOISE_RESET  = 31'd503316;

	localparam logic signed [65:0] ROUND_HALF = 66'sd8388608;
	localparam logic signed [43:0] SAT_MAX    = 44'sd2147483647;
	localparam logic signed [43:0] SAT_MIN    = -44'sd2147483648;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL,
		OP_RND,
		OP_WR,
		OP_DIV_GO,
		OP_K_WR,
		OP_OUT
	} dp_op_t;

	typedef enum logic [3:0] {
		MS_DTBB,
		MS_AA,
		MS_BB,
		MS_ANG,
		MS_BIAS,
		MS_BA,
		MS_AA2,
		MS_BB2,
		MS_AB
	} mul_step_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_RND,
		ST_WR,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_OUT
	} ctrl_state_t;

	typedef struct packed {
		dp_op_t    op;
		mul_step_t step;
		logic      ksel;
	} dp_cmd_t;

	function automatic logic signed [31:0] sat32(input logic signed [43:0] x);
		logic signed [31:0] r;
		if (x > SAT_MAX)
			r = 32'sh7fffffff;
		else if (x < SAT_MIN)
			r = 32'sh80000000;
		else
			r = x[31:0];
		return r;
	endfunction

endpackage

`default_nettype wire

@@ design/angle_bias_kalman_filter.sv @@
// Two-state angle/bias Kalman filter: one measured angle and step time in, one corrected
// angle out per item. Each item makes nine multiply, round and write passes through the
// one shared 32x34 multiplier and two bit-serial gain divisions of 56 quotient bits each,
// and then loads the output register. Input is accepted only when the previous item has
// finished; a finished result waits in the output register and the next item may enter
// meanwhile.
// Angle and bias are signed Q16.16, covariance and noise Q8.24, step time unsigned Q0.24.
// Noise registers may be written at any time the block holds no item in flight.
// Depends on abkf_pkg, abkf_ctrl, abkf_dp and abkf_div.
`default_nettype none

module angle_bias_kalman_filter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,   // [24:0] measured_angle, [48:25] step_time, pad
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [31:0] filtered_angle
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [30:0] cfg_data
);

	abkf_pkg::dp_cmd_t  cmd;
	logic               div_busy;
	logic signed [31:0] filtered_angle;

	assign cfg_ready = 1'b1;

	abkf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.div_busy (div_busy),
		.cmd      (cmd)
	);

	abkf_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.div_busy       (div_busy),
		.measured_angle ($signed(s_tdata[24:0])),
		.step_time      (s_tdata[48:25]),
		.cfg_wr         (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.filtered_angle (filtered_angle)
	);

	assign m_tdata = filtered_angle;

endmodule

`default_nettype wire

@@ design/abkf_div.sv @@
// Bit-serial signed divider for the filter gains: (num * 2^24) / den, truncated,
// saturated to signed 32 bits, zero for a zero divisor. One quotient bit per cycle.
// Depends on abkf_pkg.
`default_nettype none

module abkf_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [31:0] num,
	input  wire logic signed [32:0] den,
	output logic                    busy,
	output logic signed [31:0]      quot
);

	logic                           busy_q;
	logic [abkf_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [32:0]                    rem_q;
	logic [55:0]                    dq_q;
	logic [32:0]                    dmag_q;
	logic                           neg_q;
	logic                           zero_q;

	logic [31:0] num_mag;
	logic [32:0] den_mag;
	logic [33:0] trial;
	logic [33:0] diff;
	logic        ge;

	assign num_mag = num[31] ? (~num + 32'd1) : num;
	assign den_mag = den[32] ? (~den + 33'd1) : den;
	assign trial   = {rem_q, dq_q[55]};
	assign diff    = trial - {1'b0, dmag_q};
	assign ge      = trial >= {1'b0, dmag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= abkf_pkg::DIV_CNT_W'(abkf_pkg::DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == abkf_pkg::DIV_CNT_W'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q   <= {num_mag, 24'd0};
			dmag_q <= den_mag;
			neg_q  <= num[31] ^ den[32];
			zero_q <= (den == '0);
			rem_q  <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[32:0] : trial[32:0];
			dq_q  <= {dq_q[54:0], ge};
		end
	end

	// truncate toward zero, then saturate on the sign of the quotient
	always_comb begin
		if (zero_q)
			quot = '0;
		else if (neg_q) begin
			if ((dq_q[55:32] != '0) || (dq_q[31] && (dq_q[30:0] != '0)))
				quot = 32'sh80000000;
			else
				quot = ~dq_q[31:0] + 32'd1;
		end else begin
			if (dq_q[55:31] != '0)
				quot = 32'sh7fffffff;
			else
				quot = dq_q[31:0];
		end
	end

	assign busy = busy_q;

endmodule

`default_nettype wire

@@ design/abkf_dp.sv @@
// Datapath of the angle/bias Kalman filter: noise registers, filter state, one shared
// multiplier with rounding stage, the gain divider and the output register.
// Depends on abkf_pkg and abkf_div.
`default_nettype none

module abkf_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire abkf_pkg::dp_cmd_t                   cmd,
	output logic                                     div_busy,
	input  wire logic signed [24:0]                  measured_angle,
	input  wire logic [23:0]                         step_time,
	input  wire logic                                cfg_wr,
	input  wire logic [abkf_pkg::REG_INDEX_W-1:0]    cfg_index,
	input  wire logic [abkf_pkg::NOISE_W-1:0]        cfg_data,
	output logic signed [31:0]                       filtered_angle
);

	logic [abkf_pkg::NOISE_W-1:0] apn_q, bpn_q, mn_q;
	logic signed [31:0] ang_q, bias_q, caa_q, cab_q, cba_q, cbb_q;

	logic signed [24:0] meas_q;
	logic [23:0]        dt_q;
	logic signed [65:0] prod_q;
	logic signed [41:0] rnd_q;
	logic signed [32:0] dtbb_q;
	logic signed [33:0] inner_q;
	logic signed [31:0] y_q, k0_q, k1_q, out_q;

	logic signed [31:0] mul_a;
	logic signed [33:0] mul_b;
	logic signed [65:0] rnd_full;
	logic signed [43:0] inner_sum;
	logic signed [31:0] div_num;
	logic signed [32:0] div_den;
	logic signed [31:0] div_quot;
	logic               div_start;

	always_comb begin
		unique case (cmd.step)
			abkf_pkg::MS_DTBB: begin
				mul_a = cbb_q;
				mul_b = $signed({10'd0, dt_q});
			end
			abkf_pkg::MS_AA: begin
				mul_a = $signed({8'd0, dt_q});
				mul_b = inner_q;
			end
			abkf_pkg::MS_BB: begin
				mul_a = $signed({1'b0, bpn_q});
				mul_b = $signed({10'd0, dt_q});
			end
			abkf_pkg::MS_ANG: begin
				mul_a = k0_q;
				mul_b = 34'(y_q);
			end
			abkf_pkg::MS_BIAS: begin
				mul_a = k1_q;
				mul_b = 34'(y_q);
			end
			abkf_pkg::MS_BA: begin
				mul_a = k1_q;
				mul_b = 34'(caa_q);
			end
			abkf_pkg::MS_AA2: begin
				mul_a = k0_q;
				mul_b = 34'(caa_q);
			end
			abkf_pkg::MS_BB2: begin
				mul_a = k1_q;
				mul_b = 34'(cab_q);
			end
			abkf_pkg::MS_AB: begin
				mul_a = k0_q;
				mul_b = 34'(cab_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign rnd_full  = (prod_q + abkf_pkg::ROUND_HALF) >>> abkf_pkg::FRAC_BITS;
	assign inner_sum = 44'(rnd_q) - 44'(cab_q) - 44'(cba_q) + $signed(44'(apn_q));

	// innovation variance and gain numerator
	assign div_num   = cmd.ksel ? cba_q : caa_q;
	assign div_den   = 33'(caa_q) + $signed(33'(mn_q));
	assign div_start = (cmd.op == abkf_pkg::OP_DIV_GO);

	abkf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			apn_q  <= abkf_pkg::ANGLE_NOISE_RESET;
			bpn_q  <= abkf_pkg::BIAS_NOISE_RESET;
			mn_q   <= abkf_pkg::MEAS_NOISE_RESET;
			ang_q  <= '0;
			bias_q <= '0;
			caa_q  <= '0;
			cab_q  <= '0;
			cba_q  <= '0;
			cbb_q  <= '0;
		end else begin
			if (cfg_wr) begin
				unique case (cfg_index)
					abkf_pkg::REG_ANGLE_NOISE: apn_q <= cfg_data;
					abkf_pkg::REG_BIAS_NOISE:  bpn_q <= cfg_data;
					abkf_pkg::REG_MEAS_NOISE:  mn_q  <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.op == abkf_pkg::OP_WR) begin
				case (cmd.step)
					abkf_pkg::MS_AA: begin
						caa_q <= abkf_pkg::sat32(44'(caa_q) + 44'(rnd_q));
						cab_q <= abkf_pkg::sat32(44'(cab_q) - 44'(dtbb_q));
						cba_q <= abkf_pkg::sat32(44'(cba_q) - 44'(dtbb_q));
					end
					abkf_pkg::MS_BB:   cbb_q  <= abkf_pkg::sat32(44'(cbb_q) + 44'(rnd_q));
					abkf_pkg::MS_ANG:  ang_q  <= abkf_pkg::sat32(44'(ang_q) + 44'(rnd_q));
					abkf_pkg::MS_BIAS: bias_q <= abkf_pkg::sat32(44'(bias_q) + 44'(rnd_q));
					abkf_pkg::MS_BA:   cba_q  <= abkf_pkg::sat32(44'(cba_q) - 44'(rnd_q));
					abkf_pkg::MS_AA2:  caa_q  <= abkf_pkg::sat32(44'(caa_q) - 44'(rnd_q));
					abkf_pkg::MS_BB2:  cbb_q  <= abkf_pkg::sat32(44'(cbb_q) - 44'(rnd_q));
					abkf_pkg::MS_AB:   cab_q  <= abkf_pkg::sat32(44'(cab_q) - 44'(rnd_q));
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			abkf_pkg::OP_LOAD: begin
				meas_q <= measured_angle;
				dt_q   <= step_time;
			end
			abkf_pkg::OP_MUL: prod_q <= 66'(mul_a) * 66'(mul_b);
			abkf_pkg::OP_RND: rnd_q  <= rnd_full[41:0];
			abkf_pkg::OP_WR: begin
				if (cmd.step == abkf_pkg::MS_DTBB) begin
					dtbb_q  <= rnd_q[32:0];
					inner_q <= inner_sum[33:0];
				end
				if (cmd.step == abkf_pkg::MS_BB)
					y_q <= abkf_pkg::sat32(44'(meas_q) - 44'(ang_q));
			end
			abkf_pkg::OP_K_WR: begin
				if (cmd.ksel)
					k1_q <= div_quot;
				else
					k0_q <= div_quot;
			end
			abkf_pkg::OP_OUT: out_q <= ang_q;
			default: ;
		endcase
	end

	assign filtered_angle = out_q;

endmodule

`default_nettype wire

@@ design/abkf_ctrl.sv @@
// Sequencer of the angle/bias Kalman filter: walks each item through prediction,
// gain division and correction, and owns the stream handshakes.
// Depends on abkf_pkg.
`default_nettype none

module abkf_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	input  wire logic         div_busy,
	output abkf_pkg::dp_cmd_t cmd
);

	abkf_pkg::ctrl_state_t state_q, state_d;
	abkf_pkg::mul_step_t   step_q, step_d;
	logic                  ksel_q, ksel_d;
	logic                  out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= abkf_pkg::ST_IDLE;
			step_q      <= abkf_pkg::MS_DTBB;
			ksel_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			step_q      <= step_d;
			ksel_q      <= ksel_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		step_d      = step_q;
		ksel_d      = ksel_q;
		out_valid_d = (out_valid_q && m_tready) ? 1'b0 : out_valid_q;
		cmd.op      = abkf_pkg::OP_NONE;
		cmd.step    = step_q;
		cmd.ksel    = ksel_q;
		s_tready    = 1'b0;
		unique case (state_q)
			abkf_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.op  = abkf_pkg::OP_LOAD;
					step_d  = abkf_pkg::MS_DTBB;
					state_d = abkf_pkg::ST_MUL;
				end
			end
			abkf_pkg::ST_MUL: begin
				cmd.op  = abkf_pkg::OP_MUL;
				state_d = abkf_pkg::ST_RND;
			end
			abkf_pkg::ST_RND: begin
				cmd.op  = abkf_pkg::OP_RND;
				state_d = abkf_pkg::ST_WR;
			end
			abkf_pkg::ST_WR: begin
				cmd.op  = abkf_pkg::OP_WR;
				state_d = abkf_pkg::ST_MUL;
				case (step_q)
					abkf_pkg::MS_DTBB: step_d = abkf_pkg::MS_AA;
					abkf_pkg::MS_AA:   step_d = abkf_pkg::MS_BB;
					abkf_pkg::MS_BB: begin
						ksel_d  = 1'b0;
						state_d = abkf_pkg::ST_DIV_GO;
					end
					abkf_pkg::MS_ANG:  step_d = abkf_pkg::MS_BIAS;
					abkf_pkg::MS_BIAS: step_d = abkf_pkg::MS_BA;
					abkf_pkg::MS_BA:   step_d = abkf_pkg::MS_AA2;
					abkf_pkg::MS_AA2:  step_d = abkf_pkg::MS_BB2;
					abkf_pkg::MS_BB2:  step_d = abkf_pkg::MS_AB;
					default:           state_d = abkf_pkg::ST_OUT;
				endcase
			end
			abkf_pkg::ST_DIV_GO: begin
				cmd.op  = abkf_pkg::OP_DIV_GO;
				state_d = abkf_pkg::ST_DIV_WAIT;
			end
			abkf_pkg::ST_DIV_WAIT: begin
				if (!div_busy) begin
					cmd.op = abkf_pkg::OP_K_WR;
					if (!ksel_q) begin
						ksel_d  = 1'b1;
						state_d = abkf_pkg::ST_DIV_GO;
					end else begin
						step_d  = abkf_pkg::MS_ANG;
						state_d = abkf_pkg::ST_MUL;
					end
				end
			end
			abkf_pkg::ST_OUT: begin
				if (!out_valid_q || m_tready) begin
					cmd.op      = abkf_pkg::OP_OUT;
					out_valid_d = 1'b1;
					state_d     = abkf_pkg::ST_IDLE;
				end
			end
			default: state_d = abkf_pkg::ST_IDLE;
		endcase
	end

	assign m_tvalid = out_valid_q;

`ifndef ASSERT_OFF
	a_one_item_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while an item is in flight");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == abkf_pkg::OP_DIV_GO) |-> !div_busy)
		else $error("divider started while busy");

	a_gain_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == abkf_pkg::OP_K_WR) |-> ($past(cmd.op) != abkf_pkg::OP_DIV_GO) && !div_busy)
		else $error("gain taken before the divider finished");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == abkf_pkg::ST_OUT && m_tvalid && !m_tready) |=> (state_q == abkf_pkg::ST_OUT))
		else $error("result register overwritten before it was taken");
`endif

endmodule

`default_nettype wire
